FILE: rtl/core/fcpc_pkg.sv
// Shared types and constants for the fan curve PWM controller.
package fcpc_pkg;

	localparam int CURVE_W     = 40;
	localparam int CURVE_BYTES = CURVE_W / 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = CURVE_W;

	localparam logic [CFG_IDX_W-1:0] CFG_CURVE_TEMPS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CURVE_SPEEDS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_DIVISOR = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT   = 2'd3;

	typedef struct packed {
		logic               sample_ok;
		logic signed [31:0] raw_reading;
	} sample_t;

	typedef struct packed {
		logic [7:0]         pwm_value;
		logic               pwm_write;
		logic               temp_valid;
		logic signed [15:0] temperature_q8;
		logic [11:0]        failure_count;
		logic               sensor_failed;
	} result_t;

endpackage

FILE: rtl/core/fcpc_div.sv
// Shared restoring divider: 32-bit dividend by 16-bit divisor, one quotient bit per cycle.
module fcpc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	import fcpc_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [15:0] rem_q;
	logic [31:0] quo_q;
	logic [15:0] dvs_q;
	logic [16:0] shifted;
	logic [17:0] diff;
	logic        fits;

	always_comb begin
		shifted = {rem_q, quo_q[31]};
		diff    = {1'b0, shifted} - {2'b00, dvs_q};
		fits    = ~diff[17];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				quo_q  <= dividend;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= fits ? diff[15:0] : shifted[15:0];
				quo_q <= {quo_q[30:0], fits};
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/core/fan_curve_pwm_controller_top.sv
// Fan curve PWM controller: sensor check, curve interpolation and failure handling.
//
// A sample that fails the read or range check goes straight to the finish state. A
// reading of magnitude 1000 or more passes through the shared divider to reach 1/256
// degree; a reading inside the curve then walks the segments at one per cycle, takes
// two multiply steps and a second pass through the same divider for the rounded
// interpolation. Both passes use the 32-step restoring divider.
// in_ready is high only while no sample is in work; a finished result sits in an
// output register, so the next sample is taken while it waits for out_ready.
module fan_curve_pwm_controller_top #(
	parameter int POINTS = 5
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [fcpc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fcpc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  fcpc_pkg::sample_t                    in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output fcpc_pkg::result_t                    out_data
);
	import fcpc_pkg::*;

	localparam int SEG_W = $clog2(POINTS);
	localparam logic [SEG_W-1:0] LAST_SEG = SEG_W'(POINTS - 2);
	localparam logic [4:0] LAST_POINT = 5'(POINTS - 1);

	localparam logic signed [31:0] RAW_BIG_POS = 32'sd1000;
	localparam logic signed [31:0] RAW_BIG_NEG = -32'sd1000;
	localparam logic signed [31:0] T_MIN       = -32'sd40;
	localparam logic signed [31:0] T_MAX       = 32'sd125;
	localparam logic [15:0] DIV_DEFAULT   = 16'd1000;
	localparam logic [11:0] LIMIT_DEFAULT = 12'd10;
	localparam logic [11:0] LIMIT_MAX     = 12'd3600;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_DIVGO,
		S_DIVWAIT,
		S_EDGE,
		S_SEARCH,
		S_MUL1,
		S_MUL2,
		S_FINISH
	} state_t;

	function automatic logic [7:0] point_byte(input logic [CURVE_W-1:0] r, input logic [4:0] i);
		logic [7:0] b;
		b = '0;
		if (i < 5'(CURVE_BYTES))
			b = 8'(r >> {i, 3'b000});
		return b;
	endfunction

	// configuration
	logic [CURVE_W-1:0] temps_q;
	logic [CURVE_W-1:0] speeds_q;
	logic [15:0]        divisor_q;
	logic [11:0]        limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temps_q   <= 40'd430674420500;
			speeds_q  <= 40'd1097889284096;
			divisor_q <= 16'd1000;
			limit_q   <= 12'd10;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CURVE_TEMPS:  temps_q   <= cfg_data;
				CFG_CURVE_SPEEDS: speeds_q  <= cfg_data;
				CFG_TEMP_DIVISOR: divisor_q <= cfg_data[15:0];
				CFG_FAIL_LIMIT:   limit_q   <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// sequencer state
	state_t             state_q;
	logic               ok_q;
	logic signed [31:0] raw_q;
	logic               valid_q;
	logic               neg_q;
	logic               phase_q;
	logic signed [15:0] tq_q;
	logic [SEG_W-1:0]   seg_q;
	logic [7:0]         si_q;
	logic [7:0]         sj_q;
	logic [7:0]         r_q;
	logic [15:0]        d_q;
	logic signed [26:0] acc_q;
	logic [7:0]         spd_q;
	logic [31:0]        dvd_q;
	logic [15:0]        dvs_q;
	logic [7:0]         last_pwm_q;
	logic               known_q;
	logic [11:0]        fail_q;
	logic               out_valid_q;
	result_t            out_q;

	// shared divider
	logic        div_start;
	logic        div_done;
	logic [31:0] div_quo;

	assign div_start = (state_q == S_DIVGO);

	fcpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_q),
		.divisor  (dvs_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// range check
	logic [15:0]        div_eff;
	logic [22:0]        hi_mag;
	logic [21:0]        lo_mag;
	logic signed [32:0] hi_s;
	logic signed [32:0] lo_s;
	logic signed [32:0] raw_ext;
	logic               is_big;
	logic               big_ok;
	logic               small_ok;
	logic [31:0]        mag;

	always_comb begin
		div_eff  = (divisor_q == '0) ? DIV_DEFAULT : divisor_q;
		hi_mag   = 23'(div_eff) * 23'd125;
		lo_mag   = 22'(div_eff) * 22'd40;
		hi_s     = $signed({10'b0, hi_mag});
		lo_s     = -$signed({11'b0, lo_mag});
		raw_ext  = 33'(raw_q);
		is_big   = (raw_q <= RAW_BIG_NEG) || (raw_q >= RAW_BIG_POS);
		big_ok   = (raw_ext >= lo_s) && (raw_ext <= hi_s);
		small_ok = (raw_q >= T_MIN) && (raw_q <= T_MAX);
		mag      = raw_q[31] ? 32'(-raw_q) : 32'(raw_q);
	end

	// curve lookup
	logic signed [17:0] tq_e;
	logic [7:0]         t0;
	logic [7:0]         tl;
	logic [7:0]         ti;
	logic [7:0]         tj;
	logic signed [17:0] t0_s;
	logic signed [17:0] tl_s;
	logic signed [17:0] ti_s;
	logic signed [17:0] tj_s;
	logic signed [17:0] d_w;
	logic               in_seg;
	logic signed [8:0]  ds;
	logic signed [25:0] prod;
	logic signed [26:0] num;

	always_comb begin
		tq_e   = 18'(tq_q);
		t0     = point_byte(temps_q, 5'd0);
		tl     = point_byte(temps_q, LAST_POINT);
		ti     = point_byte(temps_q, 5'(seg_q));
		tj     = point_byte(temps_q, 5'(seg_q) + 5'd1);
		t0_s   = $signed({2'b00, t0, 8'b0});
		tl_s   = $signed({2'b00, tl, 8'b0});
		ti_s   = $signed({2'b00, ti, 8'b0});
		tj_s   = $signed({2'b00, tj, 8'b0});
		d_w    = tq_e - ti_s;
		in_seg = (tq_e >= ti_s) && (tq_e <= tj_s);
		ds     = $signed({1'b0, sj_q}) - $signed({1'b0, si_q});
		prod   = ds * $signed({1'b0, d_q});
		num    = acc_q + 27'(prod);
	end

	// result of one sample
	logic [11:0] lim;
	logic [11:0] cnt_next;
	logic        fin_failed;
	logic        fin_write;
	logic [7:0]  fin_pwm;
	logic [11:0] fin_cnt;

	always_comb begin
		lim = limit_q;
		if (limit_q == '0)
			lim = LIMIT_DEFAULT;
		else if (limit_q > LIMIT_MAX)
			lim = LIMIT_MAX;
		cnt_next = (fail_q < lim) ? fail_q + 12'd1 : fail_q;
		if (valid_q) begin
			fin_cnt    = '0;
			fin_failed = 1'b0;
			fin_write  = !known_q || (spd_q != last_pwm_q);
			fin_pwm    = fin_write ? spd_q : last_pwm_q;
		end else begin
			fin_cnt    = cnt_next;
			fin_failed = (cnt_next >= lim);
			fin_write  = fin_failed;
			fin_pwm    = fin_failed ? 8'hFF : last_pwm_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ok_q        <= 1'b0;
			raw_q       <= '0;
			valid_q     <= 1'b0;
			neg_q       <= 1'b0;
			phase_q     <= 1'b0;
			tq_q        <= '0;
			seg_q       <= '0;
			si_q        <= '0;
			sj_q        <= '0;
			r_q         <= '0;
			d_q         <= '0;
			acc_q       <= '0;
			spd_q       <= '0;
			dvd_q       <= '0;
			dvs_q       <= '0;
			last_pwm_q  <= '0;
			known_q     <= 1'b0;
			fail_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ok_q    <= in_data.sample_ok;
						raw_q   <= in_data.raw_reading;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					valid_q <= 1'b0;
					tq_q    <= '0;
					state_q <= S_FINISH;
					if (ok_q) begin
						if (is_big) begin
							if (big_ok) begin
								valid_q <= 1'b1;
								neg_q   <= raw_q[31];
								dvd_q   <= {mag[23:0], 8'b0};
								dvs_q   <= div_eff;
								phase_q <= 1'b0;
								state_q <= S_DIVGO;
							end
						end else if (small_ok) begin
							valid_q <= 1'b1;
							tq_q    <= $signed({raw_q[7:0], 8'b0});
							state_q <= S_EDGE;
						end
					end
				end
				S_DIVGO: begin
					state_q <= S_DIVWAIT;
				end
				S_DIVWAIT: begin
					if (div_done) begin
						if (!phase_q) begin
							tq_q    <= neg_q ? -$signed(div_quo[15:0]) : $signed(div_quo[15:0]);
							state_q <= S_EDGE;
						end else begin
							spd_q   <= (|div_quo[31:8]) ? 8'hFF : div_quo[7:0];
							state_q <= S_FINISH;
						end
					end
				end
				S_EDGE: begin
					seg_q <= '0;
					if (tq_e <= t0_s) begin
						spd_q   <= point_byte(speeds_q, 5'd0);
						state_q <= S_FINISH;
					end else if (tq_e >= tl_s) begin
						spd_q   <= point_byte(speeds_q, LAST_POINT);
						state_q <= S_FINISH;
					end else begin
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (in_seg) begin
						si_q <= point_byte(speeds_q, 5'(seg_q));
						sj_q <= point_byte(speeds_q, 5'(seg_q) + 5'd1);
						r_q  <= tj - ti;
						d_q  <= d_w[15:0];
						if (tj > ti) begin
							state_q <= S_MUL1;
						end else begin
							spd_q   <= point_byte(speeds_q, 5'(seg_q));
							state_q <= S_FINISH;
						end
					end else if (seg_q == LAST_SEG) begin
						// curve not ascending and no segment holds the temperature
						spd_q   <= '0;
						state_q <= S_FINISH;
					end else begin
						seg_q <= seg_q + 1'b1;
					end
				end
				S_MUL1: begin
					acc_q   <= $signed({3'b000, 16'(si_q) * 16'(r_q), 8'b0})
						+ $signed({12'b0, r_q, 7'b0});
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					dvd_q   <= num[26] ? '0 : {5'b0, num};
					dvs_q   <= {r_q, 8'b0};
					phase_q <= 1'b1;
					state_q <= S_DIVGO;
				end
				S_FINISH: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						fail_q      <= fin_cnt;
						last_pwm_q  <= fin_pwm;
						known_q     <= known_q | fin_write;
						out_valid_q <= 1'b1;
						out_q.pwm_value      <= fin_pwm;
						out_q.pwm_write      <= fin_write;
						out_q.temp_valid     <= valid_q;
						out_q.temperature_q8 <= tq_q;
						out_q.failure_count  <= fin_cnt;
						out_q.sensor_failed  <= fin_failed;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: rtl/core/fcpc_checker.sv
// Port-level checks for the fan curve PWM controller, bound to the top level.
module fcpc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cfg_we,
	input logic [fcpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [fcpc_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic                            in_valid,
	input logic                            in_ready,
	input fcpc_pkg::sample_t               in_data,
	input logic                            out_valid,
	input logic                            out_ready,
	input fcpc_pkg::result_t               out_data
);
	import fcpc_pkg::*;

	// one item in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready still high after an item was taken");

	a_failed_forces_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.sensor_failed |->
			out_data.pwm_value == 8'hFF && out_data.pwm_write)
		else $error("failed sensor without forced full speed write");

	a_invalid_zero_temp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.temp_valid |-> out_data.temperature_q8 == 16'sd0)
		else $error("invalid item carries a temperature");

	a_valid_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.temp_valid |->
			out_data.failure_count == 12'd0 && !out_data.sensor_failed)
		else $error("valid item left a failure count");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

endmodule

bind fan_curve_pwm_controller_top fcpc_checker u_fcpc_checker (.*);
